// ===== rtl/lmtc_pkg.sv =====
// ---------------------------------------------------------------------------
// lmtc_pkg
// Shared codes, reset values, result type and pattern update for the
// memory test checker.
// ---------------------------------------------------------------------------
package lmtc_pkg;

    // Default width of the word index
    localparam int INDEX_BITS_DEFAULT = 14;

    // Operation codes
    localparam logic [1:0] OP_RESTART  = 2'd0;
    localparam logic [1:0] OP_GENERATE = 2'd1;
    localparam logic [1:0] OP_CHECK    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_PATTERN_SEED = 2'd0;
    localparam logic [1:0] REG_START_INDEX  = 2'd1;
    localparam logic [1:0] REG_END_INDEX    = 2'd2;
    localparam logic [1:0] REG_REPORT_LIMIT = 2'd3;

    // Reset values
    localparam logic [31:0] SEED_RESET   = 32'h0010_0500;
    localparam logic [31:0] START_RESET  = 32'd1024;
    localparam logic [7:0]  REPORT_RESET = 8'd9;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

    // One result item
    typedef struct packed {
        logic [15:0] byte_address;
        logic [31:0] pattern_word;
        logic        mismatch;
        logic        report_error;
        logic [31:0] error_count;
        logic        range_done;
        logic        overrun;
    } result_t;

    // Shift left, feedback from taps 31, 30, 4, 3 into bit 0
    function automatic logic [31:0] lfsr_advance(input logic [31:0] p);
        logic fb;
        fb = p[31] ^ p[30] ^ p[4] ^ p[3];
        return {p[30:0], fb};
    endfunction

endpackage

// ===== rtl/lmtc_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// lmtc_cfg_regs
// Configuration register file: seed, range bounds and report limit.
// ---------------------------------------------------------------------------
module lmtc_cfg_regs #(
    parameter int INDEX_BITS = lmtc_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [1:0]            wr_index,
    input  logic [31:0]           wr_data,
    output logic [31:0]           pattern_seed,
    output logic [INDEX_BITS-1:0] start_index,
    output logic [INDEX_BITS:0]   end_index,
    output logic [7:0]            report_limit
);
    import lmtc_pkg::*;

    logic [31:0]           seed_reg;
    logic [INDEX_BITS-1:0] start_reg;
    logic [INDEX_BITS:0]   end_reg;
    logic [7:0]            limit_reg;

    // Register writes, masked to each register's width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg  <= SEED_RESET;
            start_reg <= START_RESET[INDEX_BITS-1:0];
            end_reg   <= {1'b1, {INDEX_BITS{1'b0}}};
            limit_reg <= REPORT_RESET;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_PATTERN_SEED: seed_reg  <= wr_data;
                REG_START_INDEX:  start_reg <= wr_data[INDEX_BITS-1:0];
                REG_END_INDEX:    end_reg   <= wr_data[INDEX_BITS:0];
                REG_REPORT_LIMIT: limit_reg <= wr_data[7:0];
                default:          ;
            endcase
        end
    end

    assign pattern_seed = seed_reg;
    assign start_index  = start_reg;
    assign end_index    = end_reg;
    assign report_limit = limit_reg;

endmodule

// ===== rtl/lmtc_engine.sv =====
// ---------------------------------------------------------------------------
// lmtc_engine
// Test state (pattern, word index, error count) and the per-item step logic.
// ---------------------------------------------------------------------------
module lmtc_engine #(
    parameter int INDEX_BITS = lmtc_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  logic [1:0]              operation,
    input  logic [31:0]             read_data,
    input  logic [31:0]             pattern_seed,
    input  logic [INDEX_BITS-1:0]   start_index,
    input  logic [INDEX_BITS:0]     end_index,
    input  logic [7:0]              report_limit,
    output lmtc_pkg::result_t       result
);
    import lmtc_pkg::*;

    localparam int ADDR_BITS = (INDEX_BITS + 3 > 16) ? INDEX_BITS + 3 : 16;

    logic [31:0]           pattern_reg, pattern_next;
    logic [INDEX_BITS:0]   index_reg, index_next;
    logic [31:0]           count_reg, count_next;

    logic [31:0]           cur_pattern;
    logic [INDEX_BITS:0]   cur_index;
    logic [31:0]           cur_count;
    logic                  is_restart, is_step, in_range, advance, mis, rep;
    logic [ADDR_BITS-1:0]  addr_full;

    // Restart reloads the state before the address and pattern are shown
    always_comb begin
        is_restart  = (operation == OP_RESTART);
        is_step     = (operation == OP_GENERATE) || (operation == OP_CHECK);
        cur_pattern = is_restart ? pattern_seed : pattern_reg;
        cur_index   = is_restart ? {1'b0, start_index} : index_reg;
        cur_count   = is_restart ? '0 : count_reg;
        in_range    = (cur_index < end_index);
        advance     = is_step && in_range;
        mis         = (operation == OP_CHECK) && in_range && (read_data != cur_pattern);
        count_next  = (mis && (cur_count != COUNT_MAX)) ? cur_count + 32'd1 : cur_count;
        rep         = mis && (count_next <= {24'd0, report_limit});
        index_next  = advance ? cur_index + 1'b1 : cur_index;
        pattern_next = advance ? lfsr_advance(cur_pattern) : cur_pattern;
        addr_full   = ADDR_BITS'({cur_index, 2'b00});

        result.byte_address = addr_full[15:0];
        result.pattern_word = cur_pattern;
        result.mismatch     = mis;
        result.report_error = rep;
        result.error_count  = count_next;
        result.range_done   = (index_next >= end_index);
        result.overrun      = is_step && !in_range;
    end

    // State update on each processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= SEED_RESET;
            index_reg   <= {1'b0, START_RESET[INDEX_BITS-1:0]};
            count_reg   <= '0;
        end else if (step_en) begin
            pattern_reg <= pattern_next;
            index_reg   <= index_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ===== rtl/lfsr_memory_test_checker.sv =====
// ---------------------------------------------------------------------------
// lfsr_memory_test_checker
// PRBS memory test engine: generates write addresses and patterns over a
// word range and checks read-back words, counting mismatches.
// ---------------------------------------------------------------------------
//  Channel  | Ports                                  | Moves
//  ---------+----------------------------------------+---------------------------
//  s_       | s_valid s_ready s_operation s_read_data| one operation item
//  m_       | m_valid m_ready m_byte_address ...     | one result item per input
//  cfg_     | cfg_valid cfg_ready cfg_index cfg_data | one register write
//
//  One item per cycle sustained while m_ready stays high; an item passes the input
//  register, then the step logic into the result register. The state loop
//  through the pattern shift and the error-count add sets this rate.
//  Reset (aresetn low, synchronous) loads the register defaults and the
//  test state, and empties both pipeline registers.
//  A stalled m_ side holds the result; s_ready drops only while both the
//  input and result registers are full.
// ---------------------------------------------------------------------------
module lfsr_memory_test_checker #(
    parameter int INDEX_BITS = lmtc_pkg::INDEX_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_read_data,
    // Result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_byte_address,
    output logic [31:0] m_pattern_word,
    output logic        m_mismatch,
    output logic        m_report_error,
    output logic [31:0] m_error_count,
    output logic        m_range_done,
    output logic        m_overrun,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lmtc_pkg::*;

    logic                  in_valid_reg;
    logic [1:0]            in_op_reg;
    logic [31:0]           in_data_reg;
    logic                  out_valid_reg;
    result_t               out_reg;
    result_t               step_result;
    logic                  step_en;

    logic [31:0]           pattern_seed;
    logic [INDEX_BITS-1:0] start_index;
    logic [INDEX_BITS:0]   end_index;
    logic [7:0]            report_limit;

    assign cfg_ready = 1'b1;

    lmtc_cfg_regs #(.INDEX_BITS(INDEX_BITS)) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_en        (cfg_valid),
        .wr_index     (cfg_index),
        .wr_data      (cfg_data),
        .pattern_seed (pattern_seed),
        .start_index  (start_index),
        .end_index    (end_index),
        .report_limit (report_limit)
    );

    // Handshake: the step fires when an item is held and the result slot frees
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_op_reg   <= s_operation;
            in_data_reg <= s_read_data;
        end
    end

    lmtc_engine #(.INDEX_BITS(INDEX_BITS)) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .operation    (in_op_reg),
        .read_data    (in_data_reg),
        .pattern_seed (pattern_seed),
        .start_index  (start_index),
        .end_index    (end_index),
        .report_limit (report_limit),
        .result       (step_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (step_en) begin
            out_reg <= step_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_byte_address = out_reg.byte_address;
    assign m_pattern_word = out_reg.pattern_word;
    assign m_mismatch     = out_reg.mismatch;
    assign m_report_error = out_reg.report_error;
    assign m_error_count  = out_reg.error_count;
    assign m_range_done   = out_reg.range_done;
    assign m_overrun      = out_reg.overrun;

    // Checks
    a_overrun_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overrun) |-> m_range_done)
        else $error("overrun without range_done");

    a_report_needs_mismatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_report_error) |-> m_mismatch)
        else $error("report_error without mismatch");

    a_mismatch_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_mismatch) |-> (m_error_count != 32'd0) && !m_overrun)
        else $error("mismatch with zero count or overrun");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while pipeline can move");

endmodule
